// ----- src/vfp_pkg.sv -----
package vfp_pkg;

   // Slot positions inside one job's byte sequence, in send order
   localparam logic [2:0] SLOT_START   = 3'd0;
   localparam logic [2:0] SLOT_FRAME   = 3'd1;
   localparam logic [2:0] SLOT_LEN_LO  = 3'd2;
   localparam logic [2:0] SLOT_LEN_HI  = 3'd3;
   localparam logic [2:0] SLOT_PAIR    = 3'd4;
   localparam logic [2:0] SLOT_LEFT    = 3'd5;
   localparam logic [2:0] SLOT_CSUM    = 3'd6;
   localparam logic [2:0] SLOT_TRAILER = 3'd7;

   localparam int SLOT_COUNT = 8;

   // Packet framing bytes
   localparam logic [7:0] START_BYTE   = 8'h00;
   localparam logic [7:0] TRAILER_BYTE = 8'hFF;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // One job: the bytes that a single accepted item causes
   typedef struct packed {
      logic [SLOT_COUNT-1:0] mask;  // slots to send, bit index = slot
      logic [7:0]            frame;
      logic [15:0]           len;
      logic [7:0]            pair;
      logic [7:0]            left;
      logic [7:0]            csum;
   } job_type;

endpackage

// ----- src/voxel_frame_packetizer_top.sv -----
// Voxel frame packetizer.
// req channel: one voxel per item, brightness in req_tdata (low nibble used).
// rsp channel: one packet byte per item; tuser marks the 0xFF trailer, tlast
// marks the final byte caused by one input voxel (voxels that only complete
// half a byte cause no output).
// csr channel: writes voxels_per_frame (0 acts as 1); always ready; write it
// only while no bytes are outstanding.
// Bytes pass from the job queue via a job register to the output register.
// Throughput: one voxel per cycle inside a frame; the rsp side sends one byte
// per cycle while the receiver is ready; the 4 header bytes and up to 3 trailer
// bytes at frame edges are absorbed by a 4-entry job queue between the intake
// front and the byte serializer; intake stalls only when that queue fills.
// Reset (synchronous) clears the frame position, frame number, checksum, queue
// and output valid flag, and reloads voxels_per_frame with 1331.
// A stalled receiver holds the output byte; the queue then fills and req_tready
// drops until bytes drain again.
module voxel_frame_packetizer_top #(
   parameter int FRAME_NUMBER_MODULUS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata,   // voxels_per_frame
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] voxel_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] packet_end
   output logic        rsp_tlast    // last_of_run
);

   vfp_pkg::job_type push_job;
   vfp_pkg::job_type head_job;
   logic             job_push;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;

   assign csr_ready = 1'b1;

   vfp_front #(
      .FRAME_NUMBER_MODULUS(FRAME_NUMBER_MODULUS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tready (req_tready),
      .queue_full (q_full),
      .job_push   (job_push),
      .job        (push_job)
   );

   vfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   vfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head_job   (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/vfp_front.sv -----
module vfp_front #(
   parameter int FRAME_NUMBER_MODULUS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [15:0]       csr_wdata,
   input  logic              req_tvalid,
   input  logic [7:0]        req_tdata,
   output logic              req_tready,
   input  logic              queue_full,
   output logic              job_push,
   output vfp_pkg::job_type  job
);

   localparam int FW = (FRAME_NUMBER_MODULUS > 2) ? $clog2(FRAME_NUMBER_MODULUS) : 1;

   logic [15:0]   count_cfg_ff, count_cfg_in;
   logic [15:0]   pos_ff, pos_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic [3:0]    pend_ff, pend_in;
   logic          wait_ff, wait_in;
   logic [7:0]    csum_ff, csum_in;

   logic [15:0]   count;
   logic [15:0]   len;
   logic [16:0]   len_sum;
   logic          first;
   logic          last;
   logic          wait_eff;
   logic [3:0]    pend_eff;
   logic [3:0]    nib;
   logic          w2;
   logic [3:0]    p2;
   logic          left_v;
   logic [7:0]    frame_byte;
   logic [7:0]    pair_byte;
   logic [7:0]    left_byte;
   logic [7:0]    csum_base;
   logic [7:0]    csum_after;
   logic          accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Classify the item against the frame state
   always_comb begin
      count      = (count_cfg_ff == 16'd0) ? 16'd1 : count_cfg_ff;
      len_sum    = {1'b0, count} + 17'd1;
      len        = len_sum[16:1];
      nib        = req_tdata[3:0];
      first      = (pos_ff == 16'd0);
      last       = (({1'b0, pos_ff} + 17'd1) >= {1'b0, count});
      wait_eff   = first ? 1'b0 : wait_ff;
      pend_eff   = first ? 4'd0 : pend_ff;
      frame_byte = 8'(frame_ff);
      pair_byte  = {pend_eff, nib};
      w2         = !wait_eff;
      p2         = wait_eff ? 4'd0 : nib;
      left_v     = last && w2;
      left_byte  = {p2, 4'd0};
      csum_base  = first ? (frame_byte ^ len[7:0] ^ len[15:8]) : csum_ff;
      csum_after = csum_base ^ (wait_eff ? pair_byte : 8'd0) ^ (left_v ? left_byte : 8'd0);

      job.mask = {last, last, left_v, wait_eff, first, first, first, first};
      job.frame = frame_byte;
      job.len   = len;
      job.pair  = pair_byte;
      job.left  = left_byte;
      job.csum  = csum_after;
      job_push  = accept && (first || wait_eff || last);
   end

   // Frame state update
   always_comb begin
      count_cfg_in = csr_valid ? csr_wdata : count_cfg_ff;
      pos_in       = pos_ff;
      frame_in     = frame_ff;
      pend_in      = pend_ff;
      wait_in      = wait_ff;
      csum_in      = csum_ff;
      if (accept) begin
         if (last) begin
            pos_in   = 16'd0;
            frame_in = (frame_ff == FW'(FRAME_NUMBER_MODULUS - 1)) ? '0 : frame_ff + FW'(1);
            pend_in  = 4'd0;
            wait_in  = 1'b0;
            csum_in  = 8'd0;
         end else begin
            pos_in  = pos_ff + 16'd1;
            pend_in = p2;
            wait_in = w2;
            csum_in = csum_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_cfg_ff <= 16'd1331;
         pos_ff       <= 16'd0;
         frame_ff     <= '0;
         pend_ff      <= 4'd0;
         wait_ff      <= 1'b0;
         csum_ff      <= 8'd0;
      end else begin
         count_cfg_ff <= count_cfg_in;
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         pend_ff      <= pend_in;
         wait_ff      <= wait_in;
         csum_ff      <= csum_in;
      end
   end

endmodule

// ----- src/vfp_queue.sv -----
module vfp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vfp_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output vfp_pkg::job_type  head_job
);

   vfp_pkg::job_type entry_ff [vfp_pkg::QUEUE_DEPTH];

   logic [vfp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vfp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vfp_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            do_push;
   logic                            do_pop;

   assign full     = (cnt_ff == vfp_pkg::QUEUE_CNT_W'(vfp_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + vfp_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + vfp_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + vfp_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - vfp_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/vfp_back.sv -----
module vfp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  vfp_pkg::job_type  head_job,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tuser,   // [0] packet_end
   output logic              rsp_tlast    // last_of_run
);

   vfp_pkg::job_type job_ff, job_in;

   logic [vfp_pkg::SLOT_COUNT-1:0] mask_ff, mask_in;
   logic [vfp_pkg::SLOT_COUNT-1:0] rest;
   logic                           out_valid_ff, out_valid_in;
   logic [7:0]                     out_byte_ff;
   logic                           out_end_ff;
   logic                           out_last_ff;
   logic [2:0]                     slot;
   logic [7:0]                     byte_sel;
   logic                           can_send;
   logic                           emit;
   logic                           load;

   // Lowest pending slot goes next
   always_comb begin
      slot = 3'd0;
      for (int i = vfp_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = 3'(i);
         end
      end
      rest = mask_ff & ~(vfp_pkg::SLOT_COUNT'(1) << slot);
   end

   // Byte for the selected slot
   always_comb begin
      unique case (slot)
         vfp_pkg::SLOT_START:   byte_sel = vfp_pkg::START_BYTE;
         vfp_pkg::SLOT_FRAME:   byte_sel = job_ff.frame;
         vfp_pkg::SLOT_LEN_LO:  byte_sel = job_ff.len[7:0];
         vfp_pkg::SLOT_LEN_HI:  byte_sel = job_ff.len[15:8];
         vfp_pkg::SLOT_PAIR:    byte_sel = job_ff.pair;
         vfp_pkg::SLOT_LEFT:    byte_sel = job_ff.left;
         vfp_pkg::SLOT_CSUM:    byte_sel = job_ff.csum;
         vfp_pkg::SLOT_TRAILER: byte_sel = vfp_pkg::TRAILER_BYTE;
         default:               byte_sel = vfp_pkg::START_BYTE;
      endcase
   end

   // Send and refill control
   always_comb begin
      can_send     = !out_valid_ff || rsp_tready;
      emit         = can_send && (mask_ff != '0);
      load         = !q_empty && ((mask_ff == '0) || (emit && (rest == '0)));
      q_pop        = load;
      job_in       = load ? head_job : job_ff;
      mask_in      = load ? head_job.mask : (emit ? rest : mask_ff);
      out_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         out_byte_ff <= byte_sel;
         out_end_ff  <= (slot == vfp_pkg::SLOT_TRAILER);
         out_last_ff <= (rest == '0);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_end_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- dv/tb_voxel_frame_packetizer_top.sv -----
`timescale 1ns / 100ps

// One expected byte of the packet stream
typedef struct {
   logic [7:0] data;
   logic       trailer;
   logic       last;
} packet_byte_type;

// Predicts the packet bytes caused by each accepted voxel and checks the
// bytes that come out against them, oldest first
class packet_byte_checker;
   localparam int FRAME_MOD = 64;

   logic [15:0]     voxel_count;
   int              position;
   logic [7:0]      frame_no;
   logic [3:0]      held_nibble;
   bit              nibble_held;
   logic [7:0]      checksum;
   packet_byte_type run_bytes[$];
   packet_byte_type expected_bytes[$];
   int              mismatches;
   int              voxels_taken;
   int              bytes_checked;
   int              packets_checked;
   int              count_writes;

   function void clear();
      voxel_count     = 16'd1331;
      position        = 0;
      frame_no        = 8'd0;
      held_nibble     = 4'd0;
      nibble_held     = 1'b0;
      checksum        = 8'd0;
      expected_bytes  = {};
      mismatches      = 0;
      voxels_taken    = 0;
      bytes_checked   = 0;
      packets_checked = 0;
      count_writes    = 0;
   endfunction

   function void set_count(logic [15:0] value);
      voxel_count = value;
      count_writes++;
   endfunction

   // trailer byte stays out of the checksum
   function void emit(logic [7:0] b, bit is_trailer);
      packet_byte_type pb;
      pb.data    = b;
      pb.trailer = is_trailer;
      pb.last    = 1'b0;
      run_bytes.push_back(pb);
      if (!is_trailer) checksum ^= b;
   endfunction

   function void take_voxel(logic [7:0] value);
      logic [3:0] nib;
      int         cnt;
      int         len;
      nib = value[3:0];
      cnt = (voxel_count == 16'd0) ? 1 : int'(voxel_count);
      run_bytes = {};
      voxels_taken++;

      // header goes out with the first voxel of a frame
      if (position == 0) begin
         len         = (cnt + 1) >> 1;
         checksum    = 8'd0;
         nibble_held = 1'b0;
         held_nibble = 4'd0;
         emit(vfp_pkg::START_BYTE, 1'b0);
         emit(frame_no, 1'b0);
         emit(len[7:0], 1'b0);
         emit(len[15:8], 1'b0);
      end

      // two nibbles per byte, earlier voxel high
      if (nibble_held) begin
         emit({held_nibble, nib}, 1'b0);
         nibble_held = 1'b0;
         held_nibble = 4'd0;
      end else begin
         held_nibble = nib;
         nibble_held = 1'b1;
      end

      // frame ends once the count in force is reached or passed
      if (position + 1 >= cnt) begin
         if (nibble_held) emit({held_nibble, 4'h0}, 1'b0);
         emit(checksum, 1'b0);
         emit(vfp_pkg::TRAILER_BYTE, 1'b1);
         nibble_held = 1'b0;
         held_nibble = 4'd0;
         checksum    = 8'd0;
         position    = 0;
         frame_no    = 8'((int'(frame_no) + 1) % FRAME_MOD);
      end else begin
         position = (position + 1) & 16'hFFFF;
      end

      if (run_bytes.size() > 0) run_bytes[run_bytes.size()-1].last = 1'b1;
      foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
   endfunction

   task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task check_byte(logic [7:0] data, logic trailer, logic last);
      packet_byte_type exp_b;
      if (expected_bytes.size() == 0) begin
         report($sformatf("unexpected byte %02h (tuser %b tlast %b)", data, trailer, last));
      end else begin
         exp_b = expected_bytes.pop_front();
         bytes_checked++;
         if (exp_b.trailer) packets_checked++;
         if (data !== exp_b.data)
            report($sformatf("byte %0d data %02h, expected %02h",
                             bytes_checked, data, exp_b.data));
         if (trailer !== exp_b.trailer)
            report($sformatf("byte %0d tuser %b, expected %b",
                             bytes_checked, trailer, exp_b.trailer));
         if (last !== exp_b.last)
            report($sformatf("byte %0d tlast %b, expected %b",
                             bytes_checked, last, exp_b.last));
      end
   endtask
endclass

module tb_voxel_frame_packetizer_top;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata  = 16'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   bit                 no_idle = 1'b0;
   int                 random_voxels;
   packet_byte_checker sb;

   voxel_frame_packetizer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 8);
   end

   // output monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // one voxel item; returns at the falling edge after acceptance
   task automatic send_voxel(input logic [7:0] value);
      while (!no_idle && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_voxel(value);
      @(negedge clock);
   endtask

   task automatic write_count(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_count(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for all expected bytes, then let the pipeline settle
   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (sb.expected_bytes.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (sb.expected_bytes.size() != 0) begin
         sb.report($sformatf("%0d expected bytes never arrived", sb.expected_bytes.size()));
         sb.expected_bytes = {};
      end
      repeat (8) @(negedge clock);
   endtask

   // run limit
   initial begin
      #(10_000_000);
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [15:0] count;
      int          pick;
      int          n_items;
      int          eff;

      sb = new();
      sb.clear();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset count, nibble extremes
      send_voxel(8'h00);
      send_voxel(8'hFF);
      send_voxel(8'h0F);
      send_voxel(8'hF0);
      send_voxel(8'h5A);
      drain();
      // count of one ends the open frame at once
      write_count(16'd1);
      send_voxel(8'hFF);
      send_voxel(8'h00);
      drain();
      // zero count behaves as one
      write_count(16'd0);
      send_voxel(8'hA5);
      send_voxel(8'h3C);
      drain();
      write_count(16'd2);
      send_voxel(8'h12);
      send_voxel(8'hFE);
      send_voxel(8'h87);
      send_voxel(8'h78);
      drain();
      // largest count, then shrink it mid-frame
      write_count(16'hFFFF);
      send_voxel(8'h01);
      send_voxel(8'h80);
      send_voxel(8'h7F);
      drain();
      write_count(16'd3);
      send_voxel(8'h11);
      send_voxel(8'h22);
      send_voxel(8'h33);
      drain();

      // random phases, mostly whole frames of small counts
      random_voxels = 0;
      while (random_voxels < 450) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      count = 16'($urandom_range(1, 9));
         else if (pick < 70) count = 16'($urandom_range(10, 40));
         else if (pick < 78) count = 16'd0;
         else if (pick < 84) count = 16'hFFFF;
         else                count = 16'($urandom_range(0, 65535));
         write_count(count);
         eff = (count == 16'd0) ? 1 : int'(count);
         if (pick < 78) n_items = eff * $urandom_range(1, 4);
         else           n_items = $urandom_range(3, 30);
         if (n_items > 60) n_items = 60;
         repeat (n_items) begin
            no_idle = (random_voxels >= 150 && random_voxels < 260);
            send_voxel(8'($urandom_range(0, 255)));
            random_voxels++;
         end
         no_idle = 1'b0;
         drain();
      end

      repeat (20) @(negedge clock);
      if (sb.expected_bytes.size() != 0)
         sb.report($sformatf("%0d expected bytes left over", sb.expected_bytes.size()));

      $display("Covered %0d voxels, %0d count writes, %0d packets, %0d bytes checked.",
               sb.voxels_taken, sb.count_writes, sb.packets_checked, sb.bytes_checked);
      $display("Mismatches reported: %0d", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/vfp_pkg.sv
src/vfp_front.sv
src/vfp_queue.sv
src/vfp_back.sv
src/voxel_frame_packetizer_top.sv
dv/tb_voxel_frame_packetizer_top.sv
